### hw/rtl/cqa_pkg.sv
// Shared types and constants for the consolidated quote aggregator.
package cqa_pkg;

  localparam int DEF_NUM_VENUES = 8;
  localparam int DEF_IMB_FRAC   = 15;

  localparam logic [3:0]  NO_VENUE  = 4'd8;
  localparam logic [31:0] ASK_NONE  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] bid_price;
    logic [31:0] bid_size;
    logic [31:0] ask_price;
    logic [31:0] ask_size;
    logic [15:0] imb;
    logic [39:0] mid;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OLD,
    S_MUL1,
    S_MUL2,
    S_DIVN,
    S_WAITN,
    S_WAITO,
    S_WR,
    S_SCAN,
    S_SCAN_END,
    S_EMIT,
    S_EMIT_LD
  } state_t;

endpackage

### hw/rtl/cqa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cqa_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cqa_div.sv
// Restoring serial divider, one quotient bit per cycle.
module cqa_div #(
  parameter int DW = 16,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] den_r;
  logic [VW:0]   shl;
  logic [VW:0]   diff;

  assign shl  = {rem_r, dvd_r[DW-1]};
  assign diff = shl - {1'b0, den_r};

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CW'(DW);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (shl >= {1'b0, den_r}) begin
        rem_nxt = diff[VW-1:0];
        dvd_nxt = {dvd_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shl[VW-1:0];
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = dvd_r;

endmodule

### hw/rtl/consolidated_quote_aggregator_core.sv
// Top level of the consolidated quote aggregator.
//
// Input channel (in_*): one venue quote per item, bid/ask price and size.
// Output channel (out_*): one item per other valid venue, ascending venue
// order, out_last set on the final item of a quote. A quote from a venue at
// or above NUM_VENUES is dropped; a quote with no other valid venue yields
// nothing.
// Per quote the sequencer reads the old snapshot from the venue RAM,
// updates totals and best prices, forms two products, then runs two serial
// dividers: net and own imbalance share one while the weighted mid runs
// beside it. The new entry is written back, a rescan of N venue reads
// follows only when the best venue did not improve, and each result
// passes through the RAM read in S_EMIT and the load in S_EMIT_LD.
// in_stall stays high until the last result is in the output register.
// Reset clears valid bits, totals and best prices; the RAM needs no clear.
// A stalled receiver holds the output register; the sequencer waits on it.
module consolidated_quote_aggregator_core
  import cqa_pkg::*;
#(
  parameter int NUM_VENUES              = DEF_NUM_VENUES,
  parameter int IMBALANCE_FRACTION_BITS = DEF_IMB_FRAC
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_venue,
  input  logic [31:0] in_bid_price,
  input  logic [31:0] in_bid_size,
  input  logic [31:0] in_ask_price,
  input  logic [31:0] in_ask_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_other_venue,
  output logic signed [32:0] out_spread_other_ask,
  output logic signed [32:0] out_spread_own_ask,
  output logic [31:0] out_best_bid_price,
  output logic [3:0]  out_best_bid_venue,
  output logic [31:0] out_best_ask_price,
  output logic [3:0]  out_best_ask_venue,
  output logic signed [15:0] out_own_imbalance,
  output logic signed [15:0] out_other_imbalance,
  output logic signed [15:0] out_net_imbalance,
  output logic [39:0] out_weighted_divergence,
  output logic        out_last
);

  localparam int NV  = NUM_VENUES;
  localparam int F   = IMBALANCE_FRACTION_BITS;
  localparam int IW  = $clog2(NV);
  localparam int IDW = 36 + F;
  localparam int MDW = 74;

  state_t state_r, state_nxt;

  logic [NV-1:0] valid_r;
  logic [IW-1:0] v_r, k_r, pk_r;
  logic          pend_r;
  logic          scan_bid_r, scan_ask_r;
  logic [31:0]   qbp_r, qbs_r, qap_r, qas_r;
  logic [34:0]   tot_bid_r, tot_ask_r;
  logic [31:0]   best_bid_r, best_ask_r;
  logic [3:0]    best_bid_v_r, best_ask_v_r;
  logic [63:0]   p1_r, p2_r;
  logic [15:0]   net_imb_r, own_imb_r;
  logic [39:0]   own_mid_r;

  logic [7:0]    ven8;
  logic [IW-1:0] in_v;
  logic          in_acc;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  ent_t          ram_wdata, rd;
  logic [ENT_W-1:0] rd_bits;

  // dividers
  logic           imb_start, imb_busy, mid_start, mid_busy;
  logic [IDW-1:0] imb_dvd, imb_q;
  logic [35:0]    imb_den;
  logic [MDW-1:0] mid_dvd, mid_q;
  logic [32:0]    mid_den;

  logic [NV-1:0] tgt;
  logic          is_tgt, is_last, k_end, out_free;
  logic [7:0]    k8;

  assign ven8   = {5'b0, in_venue};
  assign in_v   = ven8[IW-1:0];
  assign in_acc = in_valid && !in_stall;
  assign rd     = ent_t'(rd_bits);
  assign k8     = 8'(k_r);
  assign k_end  = (k_r == IW'(NV - 1));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    tgt = valid_r;
    tgt[v_r] = 1'b0;
  end
  assign is_tgt  = tgt[k_r];
  assign is_last = ((tgt >> k_r) >> 1) == '0;

  // rounding, saturation, sign and zero-denominator handling of a raw imbalance quotient
  function automatic logic [15:0] imb_fin(input logic [IDW-1:0] q, input logic neg,
                                          input logic den_zero);
    logic [IDW:0]   qp;
    logic [IDW-1:0] qh, lim, sat;
    logic [31:0]    mag, val;
    qp  = {1'b0, q} + 1'b1;
    qh  = qp[IDW:1];
    lim = IDW'((64'd1 << F) - 64'd1);
    sat = (qh > lim) ? lim : qh;
    mag = 32'(sat[F-1:0]);
    val = neg ? (32'd0 - mag) : mag;
    if (den_zero) begin
      val = '0;
    end
    return val[15:0];
  endfunction

  // imbalance operands: net totals in S_DIVN, this quote's sizes after
  logic [34:0] ib, ia, inum;
  always_comb begin
    if (state_r == S_DIVN) begin
      ib = tot_bid_r;
      ia = tot_ask_r;
    end else begin
      ib = 35'(qbs_r);
      ia = 35'(qas_r);
    end
    inum = (ib > ia) ? ib - ia : ia - ib;
  end
  assign imb_dvd = {inum, (F + 1)'(0)};
  assign imb_den = {1'b0, ib} + {1'b0, ia};

  logic [64:0] psum;
  assign psum    = {1'b0, p1_r} + {1'b0, p2_r};
  assign mid_dvd = {psum, 9'b0};
  assign mid_den = {1'b0, qbs_r} + {1'b0, qas_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && ven8 < 8'(NV)) state_nxt = S_OLD;
      S_OLD:   state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_DIVN;
      S_DIVN:  state_nxt = S_WAITN;
      S_WAITN: if (!imb_busy) state_nxt = S_WAITO;
      S_WAITO: if (!imb_busy && !mid_busy) state_nxt = S_WR;
      S_WR: begin
        if (scan_bid_r || scan_ask_r) state_nxt = S_SCAN;
        else if (tgt == '0)          state_nxt = S_IDLE;
        else                         state_nxt = S_EMIT;
      end
      S_SCAN:     if (k_end) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = (tgt == '0) ? S_IDLE : S_EMIT;
      S_EMIT:     if (is_tgt) state_nxt = S_EMIT_LD;
      S_EMIT_LD:  if (out_free) state_nxt = is_last ? S_IDLE : S_EMIT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    ram_raddr = k_r;
    if (state_r == S_IDLE) begin
      ram_raddr = in_v;
    end
    ram_we    = (state_r == S_WR);
    imb_start = (state_r == S_DIVN) || (state_r == S_WAITN && !imb_busy);
    mid_start = (state_r == S_DIVN);
  end

  always_comb begin
    ram_wdata.bid_price = qbp_r;
    ram_wdata.bid_size  = qbs_r;
    ram_wdata.ask_price = qap_r;
    ram_wdata.ask_size  = qas_r;
    ram_wdata.imb       = own_imb_r;
    ram_wdata.mid       = own_mid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      pend_r       <= 1'b0;
      tot_bid_r    <= '0;
      tot_ask_r    <= '0;
      best_bid_r   <= '0;
      best_bid_v_r <= NO_VENUE;
      best_ask_r   <= ASK_NONE;
      best_ask_v_r <= NO_VENUE;
      out_valid    <= 1'b0;
      scan_bid_r   <= 1'b0;
      scan_ask_r   <= 1'b0;
      k_r          <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_SCAN);
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        S_OLD: begin
          valid_r[v_r] <= 1'b1;
          if (valid_r[v_r]) begin
            tot_bid_r <= tot_bid_r - 35'(rd.bid_size) + 35'(qbs_r);
            tot_ask_r <= tot_ask_r - 35'(rd.ask_size) + 35'(qas_r);
          end else begin
            tot_bid_r <= tot_bid_r + 35'(qbs_r);
            tot_ask_r <= tot_ask_r + 35'(qas_r);
          end
          scan_bid_r <= 1'b0;
          scan_ask_r <= 1'b0;
          if (qbp_r > best_bid_r) begin
            best_bid_r   <= qbp_r;
            best_bid_v_r <= 4'(v_r);
          end else if (best_bid_v_r == 4'(v_r)) begin
            scan_bid_r <= 1'b1;
          end
          if (qap_r < best_ask_r) begin
            best_ask_r   <= qap_r;
            best_ask_v_r <= 4'(v_r);
          end else if (best_ask_v_r == 4'(v_r)) begin
            scan_ask_r <= 1'b1;
          end
        end
        S_WR: begin
          k_r <= '0;
          if (scan_bid_r) begin
            best_bid_r   <= '0;
            best_bid_v_r <= NO_VENUE;
          end
          if (scan_ask_r) begin
            best_ask_r   <= ASK_NONE;
            best_ask_v_r <= NO_VENUE;
          end
        end
        S_SCAN: begin
          if (!k_end) k_r <= k_r + 1'b1;
        end
        S_SCAN_END: k_r <= '0;
        S_EMIT: begin
          if (!is_tgt && !k_end) k_r <= k_r + 1'b1;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (!k_end) k_r <= k_r + 1'b1;
          end
        end
        default: ;
      endcase

      // rescan compare, in the cycle after the read
      if (pend_r && valid_r[pk_r]) begin
        if (scan_bid_r && (best_bid_v_r == NO_VENUE || rd.bid_price > best_bid_r)) begin
          best_bid_r   <= rd.bid_price;
          best_bid_v_r <= 4'(pk_r);
        end
        if (scan_ask_r && (best_ask_v_r == NO_VENUE || rd.ask_price < best_ask_r)) begin
          best_ask_r   <= rd.ask_price;
          best_ask_v_r <= 4'(pk_r);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pk_r <= k_r;
    if (state_r == S_IDLE) begin
      v_r   <= in_v;
      qbp_r <= in_bid_price;
      qbs_r <= in_bid_size;
      qap_r <= in_ask_price;
      qas_r <= in_ask_size;
    end
    if (state_r == S_MUL1) p1_r <= qbp_r * qas_r;
    if (state_r == S_MUL2) p2_r <= qap_r * qbs_r;
    // operand mux has moved to the quote sizes here, so test the totals
    if (state_r == S_WAITN && !imb_busy) begin
      net_imb_r <= imb_fin(imb_q, tot_bid_r < tot_ask_r,
                           (tot_bid_r == '0) && (tot_ask_r == '0));
    end
    if (state_r == S_WAITO && !imb_busy && !mid_busy) begin
      own_imb_r <= imb_fin(imb_q, qbs_r < qas_r, imb_den == '0);
      if (mid_den == '0) begin
        own_mid_r <= 40'({1'b0, qbp_r} + {1'b0, qap_r}) << 7;
      end else begin
        own_mid_r <= 40'((42'(mid_q[40:0]) + 42'd1) >> 1);
      end
    end
    if (state_r == S_EMIT_LD && out_free) begin
      out_other_venue         <= k8[2:0];
      out_spread_other_ask    <= {1'b0, rd.ask_price} - {1'b0, qbp_r};
      out_spread_own_ask      <= {1'b0, qap_r} - {1'b0, rd.bid_price};
      out_best_bid_price      <= best_bid_r;
      out_best_bid_venue      <= best_bid_v_r;
      out_best_ask_price      <= best_ask_r;
      out_best_ask_venue      <= best_ask_v_r;
      out_own_imbalance       <= own_imb_r;
      out_other_imbalance     <= rd.imb;
      out_net_imbalance       <= net_imb_r;
      out_weighted_divergence <= (own_mid_r > rd.mid) ? own_mid_r - rd.mid
                                                      : rd.mid - own_mid_r;
      out_last                <= is_last;
    end
  end

  cqa_ram #(.W(ENT_W), .D(NV)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (v_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  cqa_div #(.DW(IDW), .VW(36)) u_imb_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (imb_start),
    .dividend (imb_dvd),
    .divisor  (imb_den),
    .busy     (imb_busy),
    .quotient (imb_q)
  );

  cqa_div #(.DW(MDW), .VW(33)) u_mid_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mid_start),
    .dividend (mid_dvd),
    .divisor  (mid_den),
    .busy     (mid_busy),
    .quotient (mid_q)
  );

`ifndef SYNTHESIS
  a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !imb_busy && !mid_busy)
    else $error("divider busy while idle");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_LD |-> valid_r[k_r] && k_r != v_r)
    else $error("emitting for an invalid or own venue");

  a_imb_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
    imb_busy |-> state_r == S_WAITN || state_r == S_WAITO)
    else $error("imbalance divider running outside wait states");

  a_own_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> valid_r[v_r])
    else $error("write-back for venue not marked valid");
`endif

endmodule
